>>> design/spc_pkg.sv
// Shared constants, types and helper functions of the subtitle pixel compositor.
package spc_pkg;

   // Frame store and palette geometry.
   localparam int MAX_WIDTH     = 512;
   localparam int MAX_HEIGHT    = 128;
   localparam int PALETTE_DEPTH = 256;

   localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int CNT_W       = ADDR_W + 1;
   localparam int DX_W        = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int DY_W        = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int PIDX_W      = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

   // Field widths fixed by the interface.
   localparam int POS_W      = 12;
   localparam int WIDTH_W    = 10;
   localparam int HEIGHT_W   = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 12;

   // Command codes.
   localparam logic [2:0] CMD_CLEAR     = 3'd0;
   localparam logic [2:0] CMD_COV_BLEND = 3'd1;
   localparam logic [2:0] CMD_PAL_BLEND = 3'd2;
   localparam logic [2:0] CMD_PAL_WRITE = 3'd3;
   localparam logic [2:0] CMD_READ      = 3'd4;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_BOX_LEFT   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_BOX_TOP    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_BOX_WIDTH  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_BOX_HEIGHT = 2'd3;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic locate;
      logic pal_write;
      logic fetch;
      logic mix;
      logic write;
      logic clear;
      logic rsp_load;
   } ctl_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [2:0] cmd;
      logic       clear_done;
      logic       rsp_free;
   } sts_type;

   // Exact x / 255 for x up to 255 * 255.
   function automatic logic [7:0] div255(input logic [15:0] x);
      logic [16:0] sum;
      sum = 17'(x) + 17'(x[15:8]) + 17'd1;
      return sum[15:8];
   endfunction

endpackage

>>> design/subtitle_pixel_compositor_core.sv
// Top level of the subtitle pixel compositor: controller and datapath.
//
//   Channel  Direction  Handshake              Payload
//   req      in         req_valid / req_ready  req_command, req_pos_x, req_pos_y,
//                                              req_level, req_palette_index,
//                                              req_color_word
//   rsp      out        rsp_valid / rsp_ready  rsp_pixel_value
//   csr      in         csr_we (no wait)       csr_index, csr_wdata
//
// One transaction is processed at a time. A blend steps through locate,
// fetch, mix and write-back; a read through locate, fetch and a last step
// that waits for a free output register; a palette write is done in the
// locate step, which also ends an unknown command; a clear sweeps the w*h
// words of the box, where w and h are the box size limited to the store.
// Each blend makes one read and one write of the frame store, whose single
// write port it shares with the clear sweep, which zeroes one word per cycle.
// Reset is synchronous and active high; it clears the controller, the box
// registers, the clear counter and the valid flag of the output register,
// while the stores and the output data keep their contents.
// A finished read result waits in the output register, and the next
// transaction is accepted while it waits; a second read then holds in its
// last step until the output register is free.
module subtitle_pixel_compositor_core
   import spc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [2:0]            req_command,
   input  logic [POS_W-1:0]      req_pos_x,
   input  logic [POS_W-1:0]      req_pos_y,
   input  logic [7:0]            req_level,
   input  logic [7:0]            req_palette_index,
   input  logic [31:0]           req_color_word,

   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [31:0]           rsp_pixel_value,

   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // Command and status signals between controller and datapath.
   ctl_type ctl;
   sts_type sts;

   // The controller sequences each transaction: locate the pixel in the box,
   // fetch the stored word and palette entry, then mix and write back (blend)
   // or load the output (read). A clear sweeps the box area, one word per cycle.
   spc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .ctl       (ctl)
   );

   // The datapath holds the box registers, the frame store, the palette,
   // the blend arithmetic and the output register.
   spc_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .ctl               (ctl),
      .sts               (sts),
      .req_command       (req_command),
      .req_pos_x         (req_pos_x),
      .req_pos_y         (req_pos_y),
      .req_level         (req_level),
      .req_palette_index (req_palette_index),
      .req_color_word    (req_color_word),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_pixel_value   (rsp_pixel_value),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

endmodule

>>> design/spc_ctrl.sv
// Controller state machine of the subtitle pixel compositor.
module spc_ctrl
   import spc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  sts_type sts,
   output ctl_type ctl
);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_LOCATE = 6'b000010,
      ST_FETCH  = 6'b000100,
      ST_MIX    = 6'b001000,
      ST_WRITE  = 6'b010000,
      ST_CLEAR  = 6'b100000
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      ctl      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               ctl.load = 1'b1;
               state_in = ST_LOCATE;
            end
         end
         ST_LOCATE: begin
            ctl.locate = 1'b1;
            case (sts.cmd)
               CMD_CLEAR: state_in = ST_CLEAR;
               CMD_COV_BLEND, CMD_PAL_BLEND, CMD_READ: state_in = ST_FETCH;
               CMD_PAL_WRITE: begin
                  ctl.pal_write = 1'b1;
                  state_in      = ST_IDLE;
               end
               default: state_in = ST_IDLE;
            endcase
         end
         ST_FETCH: begin
            ctl.fetch = 1'b1;
            state_in  = ST_MIX;
         end
         ST_MIX: begin
            if (sts.cmd == CMD_READ) begin
               if (sts.rsp_free) begin
                  ctl.rsp_load = 1'b1;
                  state_in     = ST_IDLE;
               end
            end else begin
               ctl.mix  = 1'b1;
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            ctl.write = 1'b1;
            state_in  = ST_IDLE;
         end
         ST_CLEAR: begin
            if (sts.clear_done) begin
               state_in = ST_IDLE;
            end else begin
               ctl.clear = 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // A read result is only loaded into a free output register.
   a_rsp_load_free: assert property (@(posedge clock) disable iff (reset)
      ctl.rsp_load |-> sts.rsp_free)
      else $error("response loaded while output register busy");

   // The write-back of a blend always follows its mix step.
   a_write_after_mix: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WRITE) |-> ($past(state_ff) == ST_MIX))
      else $error("write-back without mix step");

endmodule

>>> design/spc_datapath.sv
// Datapath of the subtitle pixel compositor: registers, stores and blend arithmetic.
module spc_datapath
   import spc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  ctl_type               ctl,
   output sts_type               sts,
   input  logic [2:0]            req_command,
   input  logic [POS_W-1:0]      req_pos_x,
   input  logic [POS_W-1:0]      req_pos_y,
   input  logic [7:0]            req_level,
   input  logic [7:0]            req_palette_index,
   input  logic [31:0]           req_color_word,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [31:0]           rsp_pixel_value,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // Configuration registers.
   logic [POS_W-1:0]    box_left_ff,   box_left_in;
   logic [POS_W-1:0]    box_top_ff,    box_top_in;
   logic [WIDTH_W-1:0]  box_width_ff,  box_width_in;
   logic [HEIGHT_W-1:0] box_height_ff, box_height_in;

   // Transaction fields.
   logic [2:0]       cmd_ff,   cmd_in;
   logic [POS_W-1:0] x_ff,     x_in;
   logic [POS_W-1:0] y_ff,     y_in;
   logic [7:0]       level_ff, level_in;
   logic [7:0]       pidx_ff,  pidx_in;
   logic [31:0]      color_ff, color_in;

   // Locate stage.
   logic [ADDR_W-1:0] addr_ff,     addr_in;
   logic              inside_ff,   inside_in;
   logic [CNT_W-1:0]  clr_n_ff,    clr_n_in;
   logic [CNT_W-1:0]  clr_cnt_ff,  clr_cnt_in;
   logic [15:0]       cov_prod_ff, cov_prod_in;

   // Fetch stage.
   logic [31:0] frame_rdata_ff;
   logic [31:0] pal_rdata_ff;
   logic [7:0]  cov_alpha_ff, cov_alpha_in;

   // Mix stage.
   logic [7:0]  na_ff,    na_in;
   logic [15:0] mix_r_ff, mix_r_in;
   logic [15:0] mix_g_ff, mix_g_in;
   logic [15:0] mix_b_ff, mix_b_in;

   // Output register.
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_data_ff,  rsp_data_in;

   logic [31:0] frame_mem [STORE_DEPTH];
   logic [31:0] pal_mem   [PALETTE_DEPTH];

   logic [WIDTH_W-1:0]          w_eff;
   logic [HEIGHT_W-1:0]         h_eff;
   logic [POS_W-1:0]            dx, dy;
   logic [DY_W+WIDTH_W-1:0]     row_base;
   logic [WIDTH_W+HEIGHT_W-1:0] area;
   logic                        pidx_ok;
   logic [7:0]                  mix_a, mix_cr, mix_cg, mix_cb;
   logic [8:0]                  alpha_sum;
   logic                        fs_we;
   logic [ADDR_W-1:0]           fs_waddr;
   logic [31:0]                 fs_wdata;

   // Configuration writes.
   always_comb begin
      box_left_in   = box_left_ff;
      box_top_in    = box_top_ff;
      box_width_in  = box_width_ff;
      box_height_in = box_height_ff;
      if (csr_we) begin
         case (csr_index)
            REG_BOX_LEFT:   box_left_in   = csr_wdata[POS_W-1:0];
            REG_BOX_TOP:    box_top_in    = csr_wdata[POS_W-1:0];
            REG_BOX_WIDTH:  box_width_in  = csr_wdata[WIDTH_W-1:0];
            REG_BOX_HEIGHT: box_height_in = csr_wdata[HEIGHT_W-1:0];
            default: ;
         endcase
      end
   end

   // Box limited to the store size.
   assign w_eff = (32'(box_width_ff) > MAX_WIDTH) ? WIDTH_W'(MAX_WIDTH) : box_width_ff;
   assign h_eff = (32'(box_height_ff) > MAX_HEIGHT) ? HEIGHT_W'(MAX_HEIGHT) : box_height_ff;

   assign cmd_in   = ctl.load ? req_command       : cmd_ff;
   assign x_in     = ctl.load ? req_pos_x         : x_ff;
   assign y_in     = ctl.load ? req_pos_y         : y_ff;
   assign level_in = ctl.load ? req_level         : level_ff;
   assign pidx_in  = ctl.load ? req_palette_index : pidx_ff;
   assign color_in = ctl.load ? req_color_word    : color_ff;

   assign pidx_ok = (32'(pidx_ff) < PALETTE_DEPTH);

   // Position relative to the box and its store address.
   assign dx       = x_ff - box_left_ff;
   assign dy       = y_ff - box_top_ff;
   assign row_base = dy[DY_W-1:0] * w_eff;
   assign area     = w_eff * h_eff;

   assign inside_in = ctl.locate ?
                      ((x_ff >= box_left_ff) && (y_ff >= box_top_ff) &&
                       (dx < POS_W'(w_eff)) && (dy < POS_W'(h_eff))) : inside_ff;
   assign addr_in   = ctl.locate ? (ADDR_W'(row_base) + ADDR_W'(dx[DX_W-1:0])) : addr_ff;
   assign clr_n_in  = ctl.locate ? CNT_W'(area) : clr_n_ff;
   assign cov_prod_in = ctl.locate ? (16'(level_ff) * 16'(8'hFF - color_ff[7:0]))
                                   : cov_prod_ff;

   always_comb begin
      clr_cnt_in = clr_cnt_ff;
      if (ctl.locate) begin
         clr_cnt_in = '0;
      end else if (ctl.clear) begin
         clr_cnt_in = clr_cnt_ff + CNT_W'(1);
      end
   end

   assign cov_alpha_in = ctl.fetch ? div255(cov_prod_ff) : cov_alpha_ff;

   // Source alpha and color for the blend.
   always_comb begin
      if (cmd_ff == CMD_PAL_BLEND) begin
         mix_a  = pal_rdata_ff[31:24];
         mix_cr = pal_rdata_ff[23:16];
         mix_cg = pal_rdata_ff[15:8];
         mix_cb = pal_rdata_ff[7:0];
      end else begin
         mix_a  = cov_alpha_ff;
         mix_cr = color_ff[31:24];
         mix_cg = color_ff[23:16];
         mix_cb = color_ff[15:8];
      end
   end

   assign alpha_sum = 9'(mix_a) + 9'(frame_rdata_ff[31:24]);
   assign na_in     = ctl.mix ? (alpha_sum[8] ? 8'hFF : alpha_sum[7:0]) : na_ff;
   assign mix_r_in  = ctl.mix ? (16'(mix_a) * 16'(mix_cr) +
                                 16'(8'hFF - mix_a) * 16'(frame_rdata_ff[23:16])) : mix_r_ff;
   assign mix_g_in  = ctl.mix ? (16'(mix_a) * 16'(mix_cg) +
                                 16'(8'hFF - mix_a) * 16'(frame_rdata_ff[15:8])) : mix_g_ff;
   assign mix_b_in  = ctl.mix ? (16'(mix_a) * 16'(mix_cb) +
                                 16'(8'hFF - mix_a) * 16'(frame_rdata_ff[7:0])) : mix_b_ff;

   // Single write port of the frame store, shared by clear and blend.
   always_comb begin
      fs_we    = 1'b0;
      fs_waddr = addr_ff;
      fs_wdata = {na_ff, div255(mix_r_ff), div255(mix_g_ff), div255(mix_b_ff)};
      if (ctl.clear) begin
         fs_we    = 1'b1;
         fs_waddr = clr_cnt_ff[ADDR_W-1:0];
         fs_wdata = '0;
      end else if (ctl.write) begin
         fs_we = inside_ff && ((cmd_ff != CMD_PAL_BLEND) || pidx_ok);
      end
   end

   always_ff @(posedge clock) begin
      if (fs_we) begin
         frame_mem[fs_waddr] <= fs_wdata;
      end
      if (ctl.fetch) begin
         frame_rdata_ff <= frame_mem[addr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.pal_write && pidx_ok) begin
         pal_mem[pidx_ff[PIDX_W-1:0]] <= color_ff;
      end
      if (ctl.fetch) begin
         pal_rdata_ff <= pal_mem[pidx_ff[PIDX_W-1:0]];
      end
   end

   // Output register: a read outside the box returns zero.
   assign rsp_data_in  = ctl.rsp_load ? (inside_ff ? frame_rdata_ff : 32'd0) : rsp_data_ff;
   assign rsp_valid_in = ctl.rsp_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         box_left_ff   <= '0;
         box_top_ff    <= '0;
         box_width_ff  <= '0;
         box_height_ff <= '0;
         clr_cnt_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         box_left_ff   <= box_left_in;
         box_top_ff    <= box_top_in;
         box_width_ff  <= box_width_in;
         box_height_ff <= box_height_in;
         clr_cnt_ff    <= clr_cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      x_ff         <= x_in;
      y_ff         <= y_in;
      level_ff     <= level_in;
      pidx_ff      <= pidx_in;
      color_ff     <= color_in;
      addr_ff      <= addr_in;
      inside_ff    <= inside_in;
      clr_n_ff     <= clr_n_in;
      cov_prod_ff  <= cov_prod_in;
      cov_alpha_ff <= cov_alpha_in;
      na_ff        <= na_in;
      mix_r_ff     <= mix_r_in;
      mix_g_ff     <= mix_g_in;
      mix_b_ff     <= mix_b_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign sts.cmd        = cmd_ff;
   assign sts.clear_done = (clr_cnt_ff >= clr_n_ff);
   assign sts.rsp_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_value = rsp_data_ff;

   // The clear sweep never writes past the box area.
   a_clear_in_area: assert property (@(posedge clock) disable iff (reset)
      ctl.clear |-> (clr_cnt_ff < clr_n_ff))
      else $error("clear sweep beyond box area");

   // A loaded read result is presented on the next cycle.
   a_rsp_presented: assert property (@(posedge clock) disable iff (reset)
      ctl.rsp_load |=> rsp_valid_ff)
      else $error("loaded response not presented");

endmodule
